// ===== hw/rtl/lru_voice_allocator_assert.svh =====
// Assertion macros shared by the voice allocator RTL.
// Needs nothing else; the bodies collapse to nothing when SYNTHESIS is defined.
`ifndef LRU_VOICE_ALLOCATOR_ASSERT_SVH
`define LRU_VOICE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define LVA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define LVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LVA_ASSERT(lbl, clk, rst, prop, msg)
`define LVA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/lva_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the LRU voice allocator.
// Used by lva_voice_list and lru_voice_allocator; depends on nothing.
package lva_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VOICE_W    = $clog2(NUM_VOICES);
  localparam int POS_W      = VOICE_W;
  localparam int NOTE_W     = 7;
  localparam int PORT_W     = 4;
  localparam int VOICE_OUT_W = 3;
  localparam int ACTION_W   = 2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_VOICES - 1);

  localparam logic CMD_KEY_DOWN = 1'b0;
  localparam logic CMD_KEY_UP   = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MOVE,
    ST_FINISH
  } lva_state_t;

  typedef struct packed {
    logic [POS_W-1:0]   rd_pos;
    logic [NOTE_W-1:0]  cmp_note;
    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic [NOTE_W-1:0]  wr_note;
    logic [VOICE_W-1:0] wr_voice;
  } lva_list_ctrl_t;

  typedef struct packed {
    logic               hit;
    logic [VOICE_W-1:0] rd_voice;
  } lva_list_stat_t;

  // Reported voice field: low bits of the voice index, zero-filled when narrower.
  function automatic logic [VOICE_OUT_W-1:0] voice_field(input logic [VOICE_W-1:0] v);
    logic [VOICE_W+VOICE_OUT_W-1:0] ext;
    ext = (VOICE_W + VOICE_OUT_W)'(v);
    return ext[VOICE_OUT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lva_voice_list.sv =====
`timescale 1ns / 1ps
// Move-to-front list of voices with their note tags and the shared note comparator.
// Depends on lva_pkg for widths and the control and status structs.
module lva_voice_list
  import lva_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  lva_list_ctrl_t ctrl,
  output lva_list_stat_t stat
);

  logic [NOTE_W-1:0]  order_note  [NUM_VOICES];
  logic [VOICE_W-1:0] order_voice [NUM_VOICES];

  // One list position is examined per cycle by the single comparator.
  assign stat.hit      = (order_note[ctrl.rd_pos] == ctrl.cmp_note);
  assign stat.rd_voice = order_voice[ctrl.rd_pos];

  // A commit slides the entries at positions 0..wr_pos-1 back by one and puts the new entry in front.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        order_note[i]  <= '0;
        order_voice[i] <= VOICE_W'(i);
      end
    end else if (ctrl.wr_en) begin
      for (int q = 1; q < NUM_VOICES; q++) begin
        if (POS_W'(q) <= ctrl.wr_pos) begin
          order_note[q]  <= order_note[q-1];
          order_voice[q] <= order_voice[q-1];
        end
      end
      order_note[0]  <= ctrl.wr_note;
      order_voice[0] <= ctrl.wr_voice;
    end
  end

endmodule

// ===== hw/rtl/lru_voice_allocator.sv =====
`timescale 1ns / 1ps
// LRU voice allocator: a key event from the keyboard port searches a list of
// NUM_VOICES entries from the front, one entry compared per cycle by the single
// note comparator in lva_voice_list, until a match or the back entry; a
// key-down then moves its entry to the front, stealing the back voice when none
// matches. An event from another port skips the search. One event is in work
// at a time; s_tready is high while the block waits for the next event, and a
// finished result word waits in the output register, holding a later event in
// ST_FINISH until taken. The keyboard port register may be written only while
// no event is in work.
`include "lru_voice_allocator_assert.svh"
module lru_voice_allocator
  import lva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // keyboard_port
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [3:0] source_port, [10:4] note_id, rest zero
  input  logic [0:0]  s_tuser,       // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // [2:0] voice, [3] stolen, rest zero
  output logic [1:0]  m_tuser        // [1:0] action
);

  lva_state_t            state, state_next;
  logic [PORT_W-1:0]     keyboard_port;
  logic                  cmd, cmd_next;
  logic [NOTE_W-1:0]     note, note_next;
  logic [POS_W-1:0]      pos, pos_next;
  logic [POS_W-1:0]      hit_pos, hit_pos_next;
  logic [VOICE_W-1:0]    voice, voice_next;
  logic [ACTION_W-1:0]   action, action_next;
  logic                  stolen, stolen_next;
  logic                  out_load;

  lva_list_ctrl_t        list_ctrl;
  lva_list_stat_t        list_stat;

  logic                  s_accept;
  logic [PORT_W-1:0]     in_port;
  logic [NOTE_W-1:0]     in_note;

  assign in_port  = s_tdata[PORT_W-1:0];
  assign in_note  = s_tdata[PORT_W+NOTE_W-1:PORT_W];
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  lva_voice_list u_list (
    .clk  (clk),
    .rst  (rst),
    .ctrl (list_ctrl),
    .stat (list_stat)
  );

  always_comb begin
    list_ctrl.rd_pos   = pos;
    list_ctrl.cmp_note = note;
    list_ctrl.wr_en    = (state == ST_MOVE);
    list_ctrl.wr_pos   = hit_pos;
    list_ctrl.wr_note  = note;
    list_ctrl.wr_voice = voice;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyboard_port <= '0;
    end else if (cfg_wr_en) begin
      keyboard_port <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    note    <= note_next;
    pos     <= pos_next;
    hit_pos <= hit_pos_next;
    voice   <= voice_next;
    action  <= action_next;
    stolen  <= stolen_next;
  end

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    note_next    = note;
    pos_next     = pos;
    hit_pos_next = hit_pos;
    voice_next   = voice;
    action_next  = action;
    stolen_next  = stolen;
    out_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          cmd_next    = s_tuser[0];
          note_next   = in_note;
          pos_next    = '0;
          voice_next  = '0;
          action_next = ACT_NONE;
          stolen_next = 1'b0;
          state_next  = (in_port == keyboard_port) ? ST_SEARCH : ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (list_stat.hit || pos == LAST_POS) begin
          // A key-down with no match ends here on the back entry, which is stolen.
          hit_pos_next = pos;
          if (cmd == CMD_KEY_DOWN) begin
            voice_next  = list_stat.rd_voice;
            action_next = ACT_START;
            stolen_next = !list_stat.hit;
            state_next  = ST_MOVE;
          end else begin
            if (list_stat.hit) begin
              voice_next  = list_stat.rd_voice;
              action_next = ACT_RELEASE;
            end
            state_next = ST_FINISH;
          end
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      ST_MOVE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, stolen, voice_field(voice)};
      m_tuser <= action;
    end
  end

  `LVA_ASSERT(a_foreign_port_skips_search, clk, rst, s_accept && (in_port != keyboard_port) |=> state == ST_FINISH, "event from another port was searched")
  `LVA_ASSERT(a_stolen_only_on_start, clk, rst, m_tvalid && m_tdata[3] |-> m_tuser == ACT_START, "stolen flag on a word that is not a start")
  `LVA_ASSERT(a_move_only_for_key_down, clk, rst, state == ST_MOVE |-> cmd == CMD_KEY_DOWN && action == ACT_START, "list reordered for a key-up")
  `LVA_ASSERT(a_search_in_range, clk, rst, state == ST_SEARCH |-> pos <= LAST_POS, "search ran past the back of the list")
  `LVA_ASSERT_ALWAYS(a_ready_not_while_busy, clk, s_tready |-> state == ST_IDLE || rst, "event accepted while one is in work")

endmodule
